// ----- rtl/mpva_pkg.sv -----
`timescale 1ns / 1ps
package mpva_pkg;

  // Voice states.
  localparam logic [1:0] V_FREE   = 2'd0;
  localparam logic [1:0] V_ACTIVE = 2'd1;
  localparam logic [1:0] V_HOLD   = 2'd2;

  // Key states.
  localparam logic [1:0] K_OFF      = 2'd0;
  localparam logic [1:0] K_ASSIGNED = 2'd1;
  localparam logic [1:0] K_PARKED   = 2'd2;

  // Status nibbles and controller numbers.
  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [3:0] CMD_CTRL     = 4'hB;
  localparam logic [6:0] CC_SUSTAIN   = 7'd64;
  localparam logic [6:0] CC_SOUND_OFF = 7'd120;
  localparam logic [6:0] CC_NOTES_OFF = 7'd123;
  localparam logic [6:0] SUSTAIN_MAX_OFF = 7'd63;
  localparam logic [6:0] TOP_NOTE     = 7'd119;

  localparam int KEYS = 128;

  typedef logic [29:0] freq_t;

  // Lowest octave in 6.26 format, 440 Hz times 2^((s-57)/12).
  localparam logic [31:0] FREQ_BASE [12] = '{
    32'd1097337155, 32'd1162588218, 32'd1231719311, 32'd1304961152,
    32'd1382558180, 32'd1464769368, 32'd1551869087, 32'd1644148025,
    32'd1741914154, 32'd1845493760, 32'd1955232530, 32'd2071496706
  };

  // Frequency of a note in 14.16. The octave is n/12, taken as (n*171)>>11,
  // which is exact for every 7-bit note.
  function automatic freq_t freq_of(input logic [6:0] n);
    logic [14:0] prod;
    logic [3:0]  oct;
    logic [6:0]  semi;
    logic [40:0] shifted;
    logic [40:0] sum;
    prod    = 15'(n) * 15'd171;
    oct     = prod[14:11];
    semi    = n - (7'(oct) * 7'd12);
    shifted = {9'd0, FREQ_BASE[semi[3:0]]} << oct;
    sum     = shifted + 41'd512;
    if (n > TOP_NOTE) begin
      return 30'h10000;
    end
    return sum[39:10];
  endfunction

endpackage

// ----- rtl/mpva_ram.sv -----
`timescale 1ns / 1ps
module mpva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/midi_poly_voice_allocator.sv -----
`timescale 1ns / 1ps
// A note-on goes through a free scan, an age scan when no voice is free, the park of a
// stolen key and the write; a note-off that frees a voice goes through a key scan.
// One item at a time: the input is ready only when idle, in the cycle after the last
// result is taken; all-notes-off gives a result per voice, a sustain release one per held voice.
// Reset (rst, synchronous, active high) frees all voices, turns all keys off at once
// through their valid bits and clears sustain; no clearing pass is needed.
module midi_poly_voice_allocator #(
  parameter int VOICES           = 16,
  parameter int FRAMES_PER_BLOCK = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // Bits from the lowest: status_byte[7:0], data_first[14:8], data_second[21:15],
  // stamp_time[53:22], frame_offset[63:54].
  input  logic [63:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Bits from the lowest: voice_index[3:0], freq_valid[4], note_frequency[34:5],
  // velocity_valid[35], note_velocity[42:36], gate_valid[43], gate_level[44],
  // trigger_pulse[45], write_offset[55:46].
  output logic [55:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // last_result: set on the final result caused by an item.
  output logic        m_tlast
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [VW:0] VCOUNT = (VW + 1)'(VOICES);
  localparam logic [VW:0] VLAST  = (VW + 1)'(VOICES - 1);
  localparam int unsigned FB_LAST = FRAMES_PER_BLOCK - 1;
  localparam int unsigned FB_PREV = FRAMES_PER_BLOCK - 2;
  localparam logic [7:0] KCOUNT = 8'(mpva_pkg::KEYS);

  // Sequencer states.
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_FREE_SCAN = 4'd2;
  localparam logic [3:0] S_AGE_SCAN  = 4'd3;
  localparam logic [3:0] S_PARK_RD   = 4'd4;
  localparam logic [3:0] S_PARK_WR   = 4'd5;
  localparam logic [3:0] S_ON_WR     = 4'd6;
  localparam logic [3:0] S_OFF_RD    = 4'd7;
  localparam logic [3:0] S_KEY_SCAN  = 4'd8;
  localparam logic [3:0] S_REL_WR    = 4'd9;
  localparam logic [3:0] S_ALL_OFF   = 4'd10;
  localparam logic [3:0] S_SUS_SCAN  = 4'd11;
  localparam logic [3:0] S_SEND      = 4'd12;

  // What the sequencer does after a result has been taken.
  localparam logic [1:0] MODE_ONE = 2'd0;
  localparam logic [1:0] MODE_ALL = 2'd1;
  localparam logic [1:0] MODE_SUS = 2'd2;

  logic [3:0]  state;
  logic [1:0]  mode;
  logic        sustain;
  logic [1:0]  voice_status [VOICES];
  logic [127:0] key_valid;   // a key that is not valid is off

  // The item being worked on.
  logic [3:0]  cmd;
  logic [6:0]  d1;
  logic [6:0]  d2;
  logic [31:0] stamp;
  logic [9:0]  off;
  logic [9:0]  noff;

  // Scan state; pend and best_age are shared by the voice and key scans.
  logic [VW:0]   vcnt;
  logic [VW-1:0] pvoice;
  logic [7:0]    kcnt;
  logic [6:0]    pkey;
  logic          pend;
  logic          bfound;
  logic [6:0]    bkey;
  logic [31:0]   best_age;
  logic [VW-1:0] vsel;
  logic [VW-1:0] relv;

  // Output register.
  logic [3:0]  o_voice;
  logic        o_fv;
  logic [29:0] o_freq;
  logic        o_vv;
  logic [6:0]  o_vel;
  logic        o_gv;
  logic        o_gl;
  logic        o_trig;
  logic [9:0]  o_off;
  logic        o_last;

  // Memory ports.
  logic          kst_we, kvo_we, kag_we, vno_we, vag_we;
  logic [6:0]    kst_wa, kvo_wa, kag_wa, key_ra;
  logic [1:0]    kst_wd, kst_q;
  logic [VW-1:0] kvo_wd, kvo_q;
  logic [31:0]   kag_q, vag_q;
  logic [VW-1:0] vno_wa, vag_wa, voice_ra;
  logic [6:0]    vno_wd, vno_q;

  logic [9:0]  in_off_sat;
  logic [9:0]  in_noff;
  logic [1:0]  pkey_stat;
  logic [1:0]  d1_stat;
  logic        hold_above;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_SEND);
  assign m_tlast  = o_last;
  assign m_tdata  = {o_off, o_trig, o_gl, o_gv, o_vel, o_vv, o_freq, o_fv, o_voice};

  // Offsets saturate at the last frame; a note-on keeps one frame for the trigger's fall.
  always_comb begin
    in_off_sat = s_tdata[63:54];
    if ({22'd0, s_tdata[63:54]} > FB_LAST) begin
      in_off_sat = FB_LAST[9:0];
    end
    in_noff = in_off_sat;
    if ({22'd0, in_off_sat} >= FB_LAST) begin
      in_noff = FB_PREV[9:0];
    end
  end

  assign pkey_stat = key_valid[pkey] ? kst_q : mpva_pkg::K_OFF;
  assign d1_stat   = key_valid[d1] ? kst_q : mpva_pkg::K_OFF;

  // Whether a held voice above the one being released still waits.
  always_comb begin
    hold_above = 1'b0;
    for (int j = 0; j < VOICES; j++) begin
      if (((VW + 1)'(j) > {1'b0, relv}) && (voice_status[j] == mpva_pkg::V_HOLD)) begin
        hold_above = 1'b1;
      end
    end
  end

  // Read addresses and write ports of the tables.
  always_comb begin
    key_ra   = (state == S_KEY_SCAN) ? kcnt[6:0] : d1;
    voice_ra = (state == S_AGE_SCAN) ? vcnt[VW-1:0] : vsel;
    kst_we = 1'b0; kst_wa = d1; kst_wd = mpva_pkg::K_ASSIGNED;
    kvo_we = 1'b0; kvo_wa = d1; kvo_wd = vsel;
    kag_we = 1'b0; kag_wa = d1;
    vno_we = 1'b0; vno_wa = vsel; vno_wd = d1;
    vag_we = 1'b0; vag_wa = vsel;
    unique case (state)
      S_PARK_WR: begin
        kst_we = 1'b1; kst_wa = vno_q; kst_wd = mpva_pkg::K_PARKED;
      end
      S_ON_WR: begin
        kst_we = 1'b1; kvo_we = 1'b1; kag_we = 1'b1;
        vno_we = 1'b1; vag_we = 1'b1;
      end
      S_REL_WR: begin
        kst_we = bfound; kst_wa = bkey;
        kvo_we = bfound; kvo_wa = bkey; kvo_wd = relv;
        vno_we = bfound; vno_wa = relv; vno_wd = bkey;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= MODE_ONE;
      sustain   <= 1'b0;
      key_valid <= '0;
      pend      <= 1'b0;
      bfound    <= 1'b0;
      vcnt      <= '0;
      kcnt      <= '0;
      for (int i = 0; i < VOICES; i++) begin
        voice_status[i] <= mpva_pkg::V_FREE;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd   <= s_tdata[7:4];
            d1    <= s_tdata[14:8];
            d2    <= s_tdata[21:15];
            stamp <= s_tdata[53:22];
            off   <= in_off_sat;
            noff  <= in_noff;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          mode <= MODE_ONE;
          vcnt <= '0;
          if (cmd == mpva_pkg::CMD_NOTE_ON && d2 != 7'd0) begin
            state <= S_FREE_SCAN;
          end else if (cmd == mpva_pkg::CMD_NOTE_ON || cmd == mpva_pkg::CMD_NOTE_OFF) begin
            state <= S_OFF_RD;   // key tables are read at d1 on this edge
          end else if (cmd == mpva_pkg::CMD_CTRL &&
                       (d1 == mpva_pkg::CC_SOUND_OFF || d1 == mpva_pkg::CC_NOTES_OFF)) begin
            mode  <= MODE_ALL;
            state <= S_ALL_OFF;
          end else if (cmd == mpva_pkg::CMD_CTRL && d1 == mpva_pkg::CC_SUSTAIN) begin
            sustain <= (d2 > mpva_pkg::SUSTAIN_MAX_OFF);
            mode    <= MODE_SUS;
            state   <= (d2 > mpva_pkg::SUSTAIN_MAX_OFF) ? S_IDLE : S_SUS_SCAN;
          end else begin
            state <= S_IDLE;
          end
        end
        S_FREE_SCAN: begin
          // Lowest free voice first; with none free, the oldest is stolen.
          if (voice_status[vcnt[VW-1:0]] == mpva_pkg::V_FREE) begin
            vsel  <= vcnt[VW-1:0];
            state <= S_PARK_RD;
          end else if (vcnt == VLAST) begin
            vcnt  <= '0;
            pend  <= 1'b0;
            state <= S_AGE_SCAN;
          end else begin
            vcnt <= vcnt + 1'b1;
          end
        end
        S_AGE_SCAN: begin
          if (pend && (pvoice == '0 || vag_q < best_age)) begin
            best_age <= vag_q;
            vsel     <= pvoice;
          end
          if (vcnt != VCOUNT) begin
            pvoice <= vcnt[VW-1:0];
            vcnt   <= vcnt + 1'b1;
            pend   <= 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= S_PARK_RD;
          end
        end
        S_PARK_RD: begin
          // voice_note is read at vsel on this edge.
          state <= (voice_status[vsel] == mpva_pkg::V_ACTIVE) ? S_PARK_WR : S_ON_WR;
        end
        S_PARK_WR: begin
          key_valid[vno_q] <= 1'b1;
          state <= S_ON_WR;
        end
        S_ON_WR: begin
          key_valid[d1]      <= 1'b1;
          voice_status[vsel] <= mpva_pkg::V_ACTIVE;
          o_voice <= 4'(vsel);
          o_fv    <= 1'b1;
          o_freq  <= mpva_pkg::freq_of(d1);
          o_vv    <= 1'b1;
          o_vel   <= d2;
          o_gv    <= 1'b1;
          o_gl    <= 1'b1;
          o_trig  <= 1'b1;
          o_off   <= noff;
          o_last  <= 1'b1;
          state   <= S_SEND;
        end
        S_OFF_RD: begin
          key_valid[d1] <= 1'b0;
          if (d1_stat == mpva_pkg::K_ASSIGNED) begin
            if (sustain) begin
              voice_status[kvo_q] <= mpva_pkg::V_HOLD;
              state <= S_IDLE;
            end else begin
              relv   <= kvo_q;
              kcnt   <= '0;
              pend   <= 1'b0;
              bfound <= 1'b0;
              state  <= S_KEY_SCAN;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_KEY_SCAN: begin
          // Newest parked key wins, lowest key on equal ages.
          if (pend && pkey_stat == mpva_pkg::K_PARKED && (!bfound || kag_q > best_age)) begin
            bfound   <= 1'b1;
            bkey     <= pkey;
            best_age <= kag_q;
          end
          if (kcnt != KCOUNT) begin
            pkey <= kcnt[6:0];
            kcnt <= kcnt + 8'd1;
            pend <= 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= S_REL_WR;
          end
        end
        S_REL_WR: begin
          voice_status[relv] <= bfound ? mpva_pkg::V_ACTIVE : mpva_pkg::V_FREE;
          o_voice <= 4'(relv);
          o_fv    <= bfound;
          o_freq  <= bfound ? mpva_pkg::freq_of(bkey) : 30'd0;
          o_vv    <= 1'b0;
          o_vel   <= 7'd0;
          o_gv    <= !bfound;
          o_gl    <= 1'b0;
          o_trig  <= 1'b0;
          o_off   <= off;
          o_last  <= (mode == MODE_SUS) ? !hold_above : 1'b1;
          state   <= S_SEND;
        end
        S_ALL_OFF: begin
          key_valid <= '0;
          voice_status[vcnt[VW-1:0]] <= mpva_pkg::V_FREE;
          o_voice <= 4'(vcnt[VW-1:0]);
          o_fv    <= 1'b0;
          o_freq  <= 30'd0;
          o_vv    <= 1'b0;
          o_vel   <= 7'd0;
          o_gv    <= 1'b1;
          o_gl    <= 1'b0;
          o_trig  <= 1'b0;
          o_off   <= off;
          o_last  <= (vcnt == VLAST);
          state   <= S_SEND;
        end
        S_SUS_SCAN: begin
          if (vcnt == VCOUNT) begin
            state <= S_IDLE;
          end else if (voice_status[vcnt[VW-1:0]] == mpva_pkg::V_HOLD) begin
            relv   <= vcnt[VW-1:0];
            kcnt   <= '0;
            pend   <= 1'b0;
            bfound <= 1'b0;
            state  <= S_KEY_SCAN;
          end else begin
            vcnt <= vcnt + 1'b1;
          end
        end
        S_SEND: begin
          if (m_tready) begin
            if (o_last) begin
              state <= S_IDLE;
            end else if (mode == MODE_ALL) begin
              vcnt  <= vcnt + 1'b1;
              state <= S_ALL_OFF;
            end else begin
              vcnt  <= {1'b0, relv} + 1'b1;
              state <= S_SUS_SCAN;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  mpva_ram #(.WIDTH(2), .DEPTH(mpva_pkg::KEYS)) u_key_stat (
    .clk(clk), .we(kst_we), .waddr(kst_wa), .wdata(kst_wd), .raddr(key_ra), .rdata(kst_q)
  );
  mpva_ram #(.WIDTH(VW), .DEPTH(mpva_pkg::KEYS)) u_key_voice (
    .clk(clk), .we(kvo_we), .waddr(kvo_wa), .wdata(kvo_wd), .raddr(key_ra), .rdata(kvo_q)
  );
  mpva_ram #(.WIDTH(32), .DEPTH(mpva_pkg::KEYS)) u_key_age (
    .clk(clk), .we(kag_we), .waddr(kag_wa), .wdata(stamp), .raddr(key_ra), .rdata(kag_q)
  );
  mpva_ram #(.WIDTH(7), .DEPTH(VOICES)) u_voice_note (
    .clk(clk), .we(vno_we), .waddr(vno_wa), .wdata(vno_wd), .raddr(voice_ra), .rdata(vno_q)
  );
  mpva_ram #(.WIDTH(32), .DEPTH(VOICES)) u_voice_age (
    .clk(clk), .we(vag_we), .waddr(vag_wa), .wdata(stamp), .raddr(voice_ra), .rdata(vag_q)
  );

  // The block never takes an item while a result is still on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("item accepted while result pending");

  // All-notes-off leaves every key off.
  a_all_off_keys: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALL_OFF) |=> (key_valid == '0)) else $error("keys left on");

  // A key handed to a released voice must still be live.
  a_found_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_REL_WR && bfound) |-> key_valid[bkey]) else $error("dead key chosen");

  // A trigger only ever comes with a gate going high.
  a_trig_gate: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[45]) |-> (m_tdata[43] && m_tdata[44])) else $error("trigger no gate");

endmodule
